>>> hdl/sit_pkg.sv
`default_nettype none
package sit_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int NAME_BYTES_DEF = 63;

	localparam int ID_W = 7;
	localparam int QID_W = 7;
	localparam int BYTE_W = 8;

	localparam logic CMD_INTERN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// strobes from the sequencer to the name storage
	typedef struct packed {
		logic gather_we;
		logic entry_re;
		logic entry_we;
		logic len_we;
	} sit_mem_ctl_t;

endpackage
`default_nettype wire

>>> hdl/sit_in_if.sv
`default_nettype none
interface sit_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [sit_pkg::BYTE_W-1:0]    name_byte;
	logic                          name_end;
	logic [sit_pkg::QID_W-1:0]     query_id;

	modport source (output valid, output command, output name_byte, output name_end,
		output query_id, input ready);
	modport sink (input valid, input command, input name_byte, input name_end,
		input query_id, output ready);
endinterface
`default_nettype wire

>>> hdl/sit_out_if.sv
`default_nettype none
interface sit_out_if;
	logic                          valid;
	logic                          ready;
	logic [sit_pkg::ID_W-1:0]      name_id;
	logic [sit_pkg::BYTE_W-1:0]    out_char;
	logic                          char_valid;
	logic                          run_last;

	modport source (output valid, output name_id, output out_char, output char_valid,
		output run_last, input ready);
	modport sink (input valid, input name_id, input out_char, input char_valid,
		input run_last, output ready);
endinterface
`default_nettype wire

>>> hdl/sit_mem.sv
`default_nettype none
module sit_mem #(
	parameter int TABLE_ENTRIES = sit_pkg::TABLE_ENTRIES_DEF,
	parameter int NAME_BYTES = sit_pkg::NAME_BYTES_DEF,
	parameter int EW = 6,
	parameter int IW = 6,
	parameter int LW = 6
) (
	input  wire                        clk,
	input  sit_pkg::sit_mem_ctl_t      ctl,
	input  wire  [EW-1:0]              entry_idx,
	input  wire  [IW-1:0]              byte_idx,
	input  wire  [IW-1:0]              gather_waddr,
	input  wire  [sit_pkg::BYTE_W-1:0] gather_wdata,
	input  wire  [LW-1:0]              len_wdata,
	output logic [sit_pkg::BYTE_W-1:0] entry_rdata,
	output logic [sit_pkg::BYTE_W-1:0] gather_rdata,
	output logic [LW-1:0]              len_rdata
);
	import sit_pkg::*;

	logic [BYTE_W-1:0] entry_mem [TABLE_ENTRIES * (1 << IW)];
	logic [LW-1:0]     len_mem [TABLE_ENTRIES];
	logic [BYTE_W-1:0] gather_mem [NAME_BYTES];

	// stored names: one row per entry, copied from the gather buffer
	always_ff @(posedge clk) begin
		if (ctl.entry_we) begin
			entry_mem[{entry_idx, byte_idx}] <= gather_rdata;
		end
		if (ctl.entry_re) begin
			entry_rdata <= entry_mem[{entry_idx, byte_idx}];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.len_we) begin
			len_mem[entry_idx] <= len_wdata;
		end
		len_rdata <= len_mem[entry_idx];
	end

	always_ff @(posedge clk) begin
		if (ctl.gather_we) begin
			gather_mem[gather_waddr] <= gather_wdata;
		end
		gather_rdata <= gather_mem[byte_idx];
	end

endmodule
`default_nettype wire

>>> hdl/string_intern_table_unit.sv
`default_nettype none
// Name interning table. Intern bytes stream in one per transfer. On the final
// byte a sequencer walks the stored entries in order through one byte
// comparator: per entry a length read and a length check, then per compared
// byte a registered memory read and a compare. A miss appends the name byte by
// byte, a read of the gather buffer and then a write to the entry. The scan
// often ends early, since most entries fail on length or first byte. A lookup
// reads the stored length, then reads and returns each byte in turn. The name
// memory is single-port. The input is not ready while a command is being
// worked on; a finished result sits in an output register, so the next item
// can be taken while it waits.
module string_intern_table_unit #(
	parameter int TABLE_ENTRIES = sit_pkg::TABLE_ENTRIES_DEF,
	parameter int NAME_BYTES = sit_pkg::NAME_BYTES_DEF
) (
	input wire        clk,
	input wire        arst_n,
	sit_in_if.sink    in_ch,
	sit_out_if.source out_ch
);
	import sit_pkg::*;

	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int IDW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
	localparam int LW = $clog2(NAME_BYTES + 1);

	localparam logic [3:0] ST_IDLE        = 4'd0;
	localparam logic [3:0] ST_LEN_RD      = 4'd1;
	localparam logic [3:0] ST_LEN_CHK     = 4'd2;
	localparam logic [3:0] ST_BYTE_RD     = 4'd3;
	localparam logic [3:0] ST_BYTE_CHK    = 4'd4;
	localparam logic [3:0] ST_COPY_RD     = 4'd5;
	localparam logic [3:0] ST_COPY_WR     = 4'd6;
	localparam logic [3:0] ST_LOOK_LEN_RD = 4'd7;
	localparam logic [3:0] ST_LOOK_LEN    = 4'd8;
	localparam logic [3:0] ST_LOOK_RD     = 4'd9;
	localparam logic [3:0] ST_LOOK_OUT    = 4'd10;
	localparam logic [3:0] ST_EMIT        = 4'd11;

	logic [3:0]        state_q;
	logic              cmd_q;
	logic [IDW-1:0]    e_q;
	logic [IW-1:0]     i_q;
	logic [IDW-1:0]    used_q;
	logic [LW-1:0]     glen_q;
	logic              gstop_q;
	logic [LW-1:0]     len_q;
	logic [IDW-1:0]    res_id_q;

	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [BYTE_W-1:0] out_char_q;
	logic              out_cv_q;
	logic              out_last_q;

	sit_mem_ctl_t      mem_ctl;
	logic [BYTE_W-1:0] entry_rdata;
	logic [BYTE_W-1:0] gather_rdata;
	logic [LW-1:0]     len_rdata;

	logic              in_fire;
	logic              can_emit;
	logic              out_load;
	logic              gather_take;
	logic [LW-1:0]     i_next_len;
	logic              scan_last;
	logic              look_last;
	logic              qid_bad;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign can_emit = !out_valid_q || out_ch.ready;
	assign out_load = can_emit && ((state_q == ST_LOOK_OUT) || (state_q == ST_EMIT));

	assign gather_take = in_fire && (in_ch.command == CMD_INTERN) && !gstop_q
		&& (in_ch.name_byte != '0) && (glen_q < LW'(NAME_BYTES));
	assign i_next_len = LW'(i_q) + LW'(1);
	assign scan_last = (i_next_len == glen_q);
	assign look_last = (i_next_len == len_q);
	assign qid_bad = (in_ch.query_id == '0) || (int'(in_ch.query_id) > TABLE_ENTRIES)
		|| (int'(in_ch.query_id) > int'(used_q));

	always_comb begin
		mem_ctl.gather_we = gather_take;
		mem_ctl.entry_re = (state_q == ST_BYTE_RD) || (state_q == ST_LOOK_RD);
		mem_ctl.entry_we = (state_q == ST_COPY_WR);
		mem_ctl.len_we = (state_q == ST_COPY_WR) && scan_last;
	end

	sit_mem #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.NAME_BYTES(NAME_BYTES),
		.EW(EW),
		.IW(IW),
		.LW(LW)
	) u_mem (
		.clk(clk),
		.ctl(mem_ctl),
		.entry_idx(e_q[EW-1:0]),
		.byte_idx(i_q),
		.gather_waddr(glen_q[IW-1:0]),
		.gather_wdata(in_ch.name_byte),
		.len_wdata(glen_q),
		.entry_rdata(entry_rdata),
		.gather_rdata(gather_rdata),
		.len_rdata(len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			glen_q <= '0;
			gstop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q <= in_ch.command;
						e_q <= '0;
						i_q <= '0;
						res_id_q <= '0;
						if (in_ch.command == CMD_INTERN) begin
							if (!gstop_q && in_ch.name_byte == '0) begin
								gstop_q <= 1'b1;
							end
							if (gather_take) begin
								glen_q <= glen_q + LW'(1);
							end
							if (in_ch.name_end) begin
								state_q <= ST_LEN_RD;
							end
						end else if (qid_bad) begin
							state_q <= ST_EMIT;
						end else begin
							e_q <= IDW'(in_ch.query_id - QID_W'(1));
							state_q <= ST_LOOK_LEN_RD;
						end
					end
				end
				ST_LEN_RD: begin
					i_q <= '0;
					if (glen_q == '0) begin
						state_q <= ST_EMIT;
					end else if (e_q == used_q) begin
						// no match: append if there is room
						state_q <= (used_q == IDW'(TABLE_ENTRIES)) ? ST_EMIT : ST_COPY_RD;
					end else begin
						state_q <= ST_LEN_CHK;
					end
				end
				ST_LEN_CHK: begin
					if (len_rdata == glen_q) begin
						state_q <= ST_BYTE_RD;
					end else begin
						e_q <= e_q + IDW'(1);
						state_q <= ST_LEN_RD;
					end
				end
				ST_BYTE_RD: begin
					state_q <= ST_BYTE_CHK;
				end
				ST_BYTE_CHK: begin
					if (entry_rdata != gather_rdata) begin
						e_q <= e_q + IDW'(1);
						state_q <= ST_LEN_RD;
					end else if (scan_last) begin
						res_id_q <= e_q + IDW'(1);
						state_q <= ST_EMIT;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= ST_BYTE_RD;
					end
				end
				ST_COPY_RD: begin
					state_q <= ST_COPY_WR;
				end
				ST_COPY_WR: begin
					if (scan_last) begin
						used_q <= used_q + IDW'(1);
						res_id_q <= e_q + IDW'(1);
						state_q <= ST_EMIT;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= ST_COPY_RD;
					end
				end
				ST_LOOK_LEN_RD: begin
					state_q <= ST_LOOK_LEN;
				end
				ST_LOOK_LEN: begin
					len_q <= len_rdata;
					state_q <= (len_rdata == '0) ? ST_EMIT : ST_LOOK_RD;
				end
				ST_LOOK_RD: begin
					state_q <= ST_LOOK_OUT;
				end
				ST_LOOK_OUT: begin
					if (can_emit) begin
						out_id_q <= '0;
						out_char_q <= entry_rdata;
						out_cv_q <= 1'b1;
						out_last_q <= look_last;
						if (look_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + IW'(1);
							state_q <= ST_LOOK_RD;
						end
					end
				end
				ST_EMIT: begin
					if (can_emit) begin
						out_id_q <= ID_W'(res_id_q);
						out_char_q <= '0;
						out_cv_q <= 1'b0;
						out_last_q <= 1'b1;
						// drop the finished gather; an empty lookup leaves it alone
						if (cmd_q == CMD_INTERN) begin
							glen_q <= '0;
							gstop_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.name_id = out_id_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.char_valid = out_cv_q;
	assign out_ch.run_last = out_last_q;

endmodule
`default_nettype wire

>>> sim/sit_checker.sv
`default_nettype none
module sit_checker #(
	parameter int TABLE_ENTRIES = sit_pkg::TABLE_ENTRIES_DEF,
	parameter int NAME_BYTES = sit_pkg::NAME_BYTES_DEF
) (
	input wire  clk,
	input wire  arst_n,
	sit_in_if   in_ch,
	sit_out_if  out_ch,
	output int  errors,
	output int  pending
);
	import sit_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]   name_id;
		logic [BYTE_W-1:0] out_char;
		logic              char_valid;
		logic              run_last;
	} sym_result_t;

	logic [BYTE_W-1:0] name_store [TABLE_ENTRIES][NAME_BYTES];
	int                name_len [TABLE_ENTRIES];
	int                names_held;
	logic [BYTE_W-1:0] partial_name [NAME_BYTES];
	int                partial_len;
	bit                partial_closed;
	sym_result_t       due_results [$];
	sym_result_t       seen;
	sym_result_t       want;

	task automatic flag_mismatch(input string msg);
		if (errors < 40) begin
			$display("sit_checker: %0t: %s", $time, msg);
		end
		errors++;
	endtask

	// first stored name equal to the gathered one, else append; 0 on empty or full
	function automatic int find_or_add();
		int  e;
		int  i;
		bit  same;
		if (partial_len == 0) begin
			return 0;
		end
		for (e = 0; e < names_held; e++) begin
			if (name_len[e] == partial_len) begin
				same = 1'b1;
				for (i = 0; i < partial_len; i++) begin
					if (name_store[e][i] != partial_name[i]) begin
						same = 1'b0;
					end
				end
				if (same) begin
					return e + 1;
				end
			end
		end
		if (names_held < TABLE_ENTRIES) begin
			for (i = 0; i < partial_len; i++) begin
				name_store[names_held][i] = partial_name[i];
			end
			name_len[names_held] = partial_len;
			names_held++;
			return names_held;
		end
		return 0;
	endfunction

	task automatic predict_command(input logic cmd, input logic [BYTE_W-1:0] b,
		input logic fin, input logic [QID_W-1:0] q);
		int k;
		int id;
		int e;
		if (cmd == CMD_INTERN) begin
			if (!partial_closed) begin
				if (b == '0) begin
					partial_closed = 1'b1;
				end else if (partial_len < NAME_BYTES) begin
					partial_name[partial_len] = b;
					partial_len++;
				end
			end
			if (fin) begin
				id = find_or_add();
				partial_len = 0;
				partial_closed = 1'b0;
				due_results.push_back('{ID_W'(id), '0, 1'b0, 1'b1});
			end
		end else begin
			if (q == 0 || q > TABLE_ENTRIES || q > names_held) begin
				due_results.push_back('{'0, '0, 1'b0, 1'b1});
			end else begin
				e = int'(q) - 1;
				for (k = 0; k < name_len[e]; k++) begin
					due_results.push_back('{'0, name_store[e][k], 1'b1,
						(k == name_len[e] - 1)});
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			names_held = 0;
			partial_len = 0;
			partial_closed = 1'b0;
			due_results.delete();
			errors = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_command(in_ch.command, in_ch.name_byte, in_ch.name_end,
					in_ch.query_id);
			end
			if (out_ch.valid && out_ch.ready) begin
				seen = '{out_ch.name_id, out_ch.out_char, out_ch.char_valid, out_ch.run_last};
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result id %0d char %02h cv %0b last %0b",
						seen.name_id, seen.out_char, seen.char_valid, seen.run_last));
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						flag_mismatch($sformatf(
							"got id %0d char %02h cv %0b last %0b, want id %0d char %02h cv %0b last %0b",
							seen.name_id, seen.out_char, seen.char_valid, seen.run_last,
							want.name_id, want.out_char, want.char_valid, want.run_last));
					end
				end
			end
		end
		pending = due_results.size();
	end

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
module tb_top;
	import sit_pkg::*;

	typedef logic [BYTE_W-1:0] name_q_t [$];

	localparam int QUIET_LIMIT = 50000;
	localparam int HOLD_STRETCH = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   src_idle;
	int   sink_stall;
	int   hold_cycles;
	int   items_sent;
	name_q_t  nm;
	name_q_t  name_log [$];

	sit_in_if  in_ch ();
	sit_out_if out_ch ();

	string_intern_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sit_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_stall);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic put_item(input logic cmd, input logic [BYTE_W-1:0] b, input logic fin,
		input logic [QID_W-1:0] q);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.name_byte <= b;
		in_ch.name_end <= fin;
		in_ch.query_id <= q;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic lookup(input logic [QID_W-1:0] q);
		put_item(CMD_LOOKUP, BYTE_W'($urandom), 1'($urandom), q);
	endtask

	// stream one name; now and then slip a lookup between its bytes
	task automatic send_name(input name_q_t n);
		int k;
		for (k = 0; k < n.size(); k++) begin
			if ($urandom_range(99) < 8) begin
				lookup(QID_W'($urandom_range(1, 64)));
			end
			put_item(CMD_INTERN, n[k], (k == n.size() - 1), QID_W'($urandom));
		end
	endtask

	task automatic wait_results();
		in_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow);
		if ($urandom_range(99) < 4) begin
			return '0;
		end
		if (narrow) begin
			return BYTE_W'($urandom_range(8'h61, 8'h64));
		end
		return BYTE_W'($urandom_range(1, 255));
	endfunction

	function automatic name_q_t make_name();
		name_q_t n;
		int r;
		int len;
		int k;
		bit narrow;
		r = $urandom_range(99);
		if (r < 45 && name_log.size() > 0) begin
			n = name_log[$urandom_range(name_log.size() - 1)];
			// near miss: alter, grow or shrink a known name
			if (r >= 30) begin
				case ($urandom_range(2))
					0: n[$urandom_range(n.size() - 1)] = pick_byte(1'b0);
					1: n.push_back(pick_byte(1'b1));
					default: void'(n.pop_back());
				endcase
			end
		end else begin
			narrow = $urandom_range(1);
			if ($urandom_range(99) < 3) begin
				len = $urandom_range(55, 70);
			end else if ($urandom_range(99) < 15) begin
				len = $urandom_range(7, 20);
			end else begin
				len = $urandom_range(1, 6);
			end
			for (k = 0; k < len; k++) begin
				n.push_back(pick_byte(narrow));
			end
		end
		if (n.size() == 0) begin
			n.push_back(pick_byte(1'b1));
		end
		return n;
	endfunction

	task automatic random_until(input int target);
		while (items_sent < target) begin
			if ($urandom_range(99) < 40) begin
				if ($urandom_range(99) < 80) begin
					lookup(QID_W'($urandom_range(1, 64)));
				end else begin
					lookup(QID_W'($urandom_range(0, 127)));
				end
			end else begin
				nm = make_name();
				send_name(nm);
				if (name_log.size() < 200) begin
					name_log.push_back(nm);
				end
			end
		end
	endtask

	initial begin
		int k;
		in_ch.valid <= 1'b0;
		in_ch.command <= CMD_INTERN;
		in_ch.name_byte <= '0;
		in_ch.name_end <= 1'b0;
		in_ch.query_id <= '0;
		src_idle = 0;
		sink_stall = 0;
		hold_cycles = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: new names, repeats, empty names, cut by zero, bad ids
		nm = {8'h41};
		send_name(nm);
		nm = {8'hFF, 8'h80};
		send_name(nm);
		nm = {8'h41};
		send_name(nm);
		nm = {8'h00};
		send_name(nm);
		nm = {8'h41, 8'h00, 8'h42};
		send_name(nm);
		nm = {8'h00, 8'h41};
		send_name(nm);
		lookup(7'd0);
		lookup(7'd127);
		lookup(7'd64);
		lookup(7'd1);
		lookup(7'd2);
		// lookup in the middle of a gather
		put_item(CMD_INTERN, 8'h7F, 1'b0, 7'd0);
		lookup(7'd2);
		put_item(CMD_INTERN, 8'h01, 1'b1, 7'd127);
		nm = {8'h41, 8'h42};
		send_name(nm);
		nm = {8'h42, 8'h41};
		send_name(nm);
		lookup(7'd3);
		lookup(7'd4);
		wait_results();

		// long hold-off on the output while a truncated name and its readbacks pile up
		hold_cycles = HOLD_STRETCH;
		nm = {};
		for (k = 0; k < 66; k++) begin
			nm.push_back(BYTE_W'($urandom_range(1, 255)));
		end
		send_name(nm);
		name_log.push_back(nm);
		repeat (5) lookup(7'd6);
		wait_results();

		random_until(110);
		src_idle = 52;
		random_until(170);
		wait_results();
		src_idle = 0;
		sink_stall = 52;
		random_until(230);
		src_idle = 25;
		sink_stall = 25;
		random_until(290);
		wait_results();

		// fill the table, then probe it when full
		src_idle = 0;
		sink_stall = 0;
		for (k = 1; k <= 70; k++) begin
			nm = {8'hC3, BYTE_W'(k)};
			send_name(nm);
		end
		src_idle = 25;
		sink_stall = 25;
		lookup(7'd64);
		lookup(7'd65);
		lookup(7'd6);
		random_until(items_sent + 30);

		wait_results();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
